// File: hw/rtl/control_code_escape_decoder_assert.svh
// Assertion macros shared by the decoder. Define NO_ASSERTIONS to drop them.
`ifndef CONTROL_CODE_ESCAPE_DECODER_ASSERT_SVH
`define CONTROL_CODE_ESCAPE_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CCD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("escape decoder check failed");
`define CCD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape decoder check failed");
`else
`define CCD_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define CCD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/ccd_pkg.sv
`default_nettype none
package ccd_pkg;

    // Parser modes of the front end.
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_CARET  = 3'd1,
        MODE_BSLASH = 3'd2,
        MODE_STAR   = 3'd3,
        MODE_DIGITS = 3'd4,
        MODE_NAME   = 3'd5
    } t_mode;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam int NAME_MAX  = 3;
    localparam int SYM_COUNT = 44;

    typedef logic [0:NAME_MAX-1][7:0] t_name_buf;

    typedef struct packed {
        t_name_buf  txt;
        logic [1:0] len;
        logic [7:0] code;
    } t_sym;

    localparam t_sym SYM_TABLE [SYM_COUNT] = '{
        '{'{"n", "u", "l"}, 2'd3, 8'd0},   '{'{"s", "o", "h"}, 2'd3, 8'd1},
        '{'{"s", "t", "x"}, 2'd3, 8'd2},   '{'{"e", "t", "x"}, 2'd3, 8'd3},
        '{'{"e", "o", "t"}, 2'd3, 8'd4},   '{'{"e", "n", "q"}, 2'd3, 8'd5},
        '{'{"a", "c", "k"}, 2'd3, 8'd6},   '{'{"b", "e", "l"}, 2'd3, 8'd7},
        '{'{"b", "s", 8'h00}, 2'd2, 8'd8}, '{'{"h", "t", 8'h00}, 2'd2, 8'd9},
        '{'{"l", "f", 8'h00}, 2'd2, 8'd10}, '{'{"v", "t", 8'h00}, 2'd2, 8'd11},
        '{'{"f", "f", 8'h00}, 2'd2, 8'd12}, '{'{"c", "r", 8'h00}, 2'd2, 8'd13},
        '{'{"s", "o", 8'h00}, 2'd2, 8'd14}, '{'{"s", "i", 8'h00}, 2'd2, 8'd15},
        '{'{"d", "l", "e"}, 2'd3, 8'd16},  '{'{"d", "c", "1"}, 2'd3, 8'd17},
        '{'{"d", "c", "2"}, 2'd3, 8'd18},  '{'{"d", "c", "3"}, 2'd3, 8'd19},
        '{'{"d", "c", "4"}, 2'd3, 8'd20},  '{'{"n", "a", "k"}, 2'd3, 8'd21},
        '{'{"s", "y", "n"}, 2'd3, 8'd22},  '{'{"e", "t", "b"}, 2'd3, 8'd23},
        '{'{"c", "a", "n"}, 2'd3, 8'd24},  '{'{"e", "m", 8'h00}, 2'd2, 8'd25},
        '{'{"s", "u", "b"}, 2'd3, 8'd26},  '{'{"e", "s", "c"}, 2'd3, 8'd27},
        '{'{"f", "s", 8'h00}, 2'd2, 8'd28}, '{'{"g", "s", 8'h00}, 2'd2, 8'd29},
        '{'{"r", "s", 8'h00}, 2'd2, 8'd30}, '{'{"u", "s", 8'h00}, 2'd2, 8'd31},
        '{'{"s", "p", 8'h00}, 2'd2, 8'd32}, '{'{"d", "e", "l"}, 2'd3, 8'd127},
        '{'{"s", "s", "2"}, 2'd3, 8'd142}, '{'{"s", "s", "3"}, 2'd3, 8'd143},
        '{'{"d", "c", "s"}, 2'd3, 8'd144}, '{'{"c", "s", "i"}, 2'd3, 8'd155},
        '{'{"s", "t", 8'h00}, 2'd2, 8'd156}, '{'{"o", "s", "c"}, 2'd3, 8'd157},
        '{'{"p", "m", 8'h00}, 2'd2, 8'd158}, '{'{"a", "p", "c"}, 2'd3, 8'd159},
        '{'{"n", "b", "s"}, 2'd3, 8'd160}, '{'{"s", "h", "y"}, 2'd3, 8'd173}
    };

    // Channel payloads.
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_last;
        logic        string_end;
        logic [15:0] byte_count;
    } t_out_item;

    // One queued request: the results that one input item causes.
    typedef struct packed {
        logic [1:0] num_res;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       byte_valid;
        logic       string_end;
    } t_cmd;

    // Appends a byte to a request; a request holds at most two bytes.
    function automatic t_cmd cmd_push(t_cmd c, logic [7:0] b);
        t_cmd r;
        r = c;
        if (c.num_res == 2'd0) begin
            r.byte0   = b;
            r.num_res = 2'd1;
        end else if (c.num_res == 2'd1) begin
            r.byte1   = b;
            r.num_res = 2'd2;
        end
        return r;
    endfunction

    // Name table match; unused buffer positions are always zero.
    function automatic logic [7:0] name_lookup(t_name_buf nm, logic [1:0] len);
        logic [7:0] code;
        logic       found;
        code  = 8'd0;
        found = 1'b0;
        for (int k = 0; k < SYM_COUNT; k++) begin
            if (!found && SYM_TABLE[k].len == len && SYM_TABLE[k].txt == nm) begin
                code  = SYM_TABLE[k].code;
                found = 1'b1;
            end
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ccd_stream_if.sv
`default_nettype none
interface ccd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ccd_fifo.sv
`default_nettype none
module ccd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  ccd_pkg::t_cmd     i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output ccd_pkg::t_cmd     o_head
);
    import ccd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_fill;

    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/ccd_front.sv
`default_nettype none
module ccd_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ccd_stream_if.sink    i_in,
    input  wire logic     i_q_full,
    output logic          o_push,
    output ccd_pkg::t_cmd o_cmd
);
    import ccd_pkg::*;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [9:0] r_digit;
    logic [9:0] n_digit;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_name_buf  r_name;
    t_name_buf  n_name;

    logic       accept;
    logic [7:0] c;
    logic       last;
    logic [7:0] uc;
    logic [7:0] lc;
    logic       is_dig;
    logic       is_aln;
    logic [9:0] dval;
    logic [9:0] digit_acc;
    logic [2:0] cnt_inc;
    logic       do_plain;
    t_cmd       cmd;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign c          = i_in.data.in_char;
    assign last       = i_in.data.in_last;

    assign uc        = (c >= "a" && c <= "z") ? c - CASE_GAP : c;
    assign lc        = (c >= "A" && c <= "Z") ? c + CASE_GAP : c;
    assign is_dig    = (c >= "0" && c <= "9");
    assign is_aln    = is_dig || (lc >= "a" && lc <= "z");
    assign dval      = {6'd0, c[3:0]};
    assign digit_acc = 10'((r_digit << 3) + (r_digit << 1) + dval);
    assign cnt_inc   = {1'b0, r_cnt} + 3'd1;

    always_comb begin
        n_mode         = r_mode;
        n_digit        = r_digit;
        n_cnt          = r_cnt;
        n_name         = r_name;
        do_plain       = 1'b0;
        cmd            = '0;
        cmd.byte_valid = 1'b1;
        cmd.string_end = last;

        unique case (r_mode)
            MODE_CARET: begin
                cmd    = cmd_push(cmd, (uc >= "A" && uc <= CH_USCORE) ? uc - CH_AT : c);
                n_mode = MODE_NORMAL;
            end
            MODE_BSLASH: begin
                n_mode = MODE_NORMAL;
                if (uc >= "0" && uc <= "6") begin
                    cmd = cmd;
                end else begin
                    case (uc)
                        "A", "C", "D", "G", "H", "I", "P", "U", "X": begin
                            cmd = cmd_push(cmd, CH_BSLASH);
                            cmd = cmd_push(cmd, c);
                        end
                        "B":     cmd = cmd_push(cmd, 8'd8);
                        "F":     cmd = cmd_push(cmd, 8'd12);
                        "N":     cmd = cmd_push(cmd, 8'd10);
                        "R":     cmd = cmd_push(cmd, 8'd13);
                        "T":     cmd = cmd_push(cmd, 8'd9);
                        "E":     cmd = cmd_push(cmd, 8'd27);
                        CH_STAR: begin
                            n_digit = '0;
                            n_cnt   = '0;
                            n_name  = '0;
                            n_mode  = MODE_STAR;
                        end
                        default: cmd = cmd_push(cmd, c);
                    endcase
                end
            end
            MODE_STAR: begin
                if (c == CH_SPACE) begin
                    n_mode = MODE_STAR;
                end else if (is_dig) begin
                    n_digit = dval;
                    n_cnt   = 2'd1;
                    n_mode  = MODE_DIGITS;
                end else if (is_aln) begin
                    n_name[0] = lc;
                    n_cnt     = 2'd1;
                    n_mode    = MODE_NAME;
                end else begin
                    cmd      = cmd_push(cmd, 8'd0);
                    n_digit  = '0;
                    n_cnt    = '0;
                    n_name   = '0;
                    do_plain = 1'b1;
                end
            end
            MODE_DIGITS: begin
                if (is_dig && cnt_inc >= 3'd3) begin
                    cmd     = cmd_push(cmd, digit_acc[7:0]);
                    n_digit = '0;
                    n_cnt   = '0;
                    n_name  = '0;
                    n_mode  = MODE_NORMAL;
                end else if (is_dig) begin
                    n_digit = digit_acc;
                    n_cnt   = cnt_inc[1:0];
                end else begin
                    cmd      = cmd_push(cmd, r_digit[7:0]);
                    n_digit  = '0;
                    n_cnt    = '0;
                    n_name   = '0;
                    do_plain = 1'b1;
                end
            end
            MODE_NAME: begin
                if (is_aln && cnt_inc >= 3'd4) begin
                    // A four character name is longer than any table entry.
                    cmd     = cmd_push(cmd, 8'd0);
                    n_digit = '0;
                    n_cnt   = '0;
                    n_name  = '0;
                    n_mode  = MODE_NORMAL;
                end else if (is_aln) begin
                    n_name[r_cnt] = lc;
                    n_cnt         = cnt_inc[1:0];
                end else begin
                    cmd      = cmd_push(cmd, name_lookup(r_name, r_cnt));
                    n_digit  = '0;
                    n_cnt    = '0;
                    n_name   = '0;
                    do_plain = 1'b1;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        // The character that ends a code is handled as in normal mode.
        if (do_plain) begin
            if (c == CH_BSLASH) begin
                n_mode = MODE_BSLASH;
            end else if (c == CH_CARET) begin
                n_mode = MODE_CARET;
            end else begin
                n_mode = MODE_NORMAL;
                cmd    = cmd_push(cmd, c);
            end
        end

        if (last) begin
            if (n_mode == MODE_DIGITS) begin
                cmd = cmd_push(cmd, n_digit[7:0]);
            end else if (n_mode == MODE_NAME) begin
                cmd = cmd_push(cmd, name_lookup(n_name, n_cnt));
            end
            if (cmd.num_res == 2'd0) begin
                cmd.num_res    = 2'd1;
                cmd.byte0      = 8'd0;
                cmd.byte_valid = 1'b0;
            end
            n_mode  = MODE_NORMAL;
            n_digit = '0;
            n_cnt   = '0;
            n_name  = '0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.num_res != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_digit <= '0;
            r_cnt   <= '0;
            r_name  <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_digit <= n_digit;
            r_cnt   <= n_cnt;
            r_name  <= n_name;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/ccd_back.sv
`default_nettype none
module ccd_back (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_empty,
    input  ccd_pkg::t_cmd i_head,
    output logic          o_pop,
    ccd_stream_if.source  o_out
);
    import ccd_pkg::*;

    logic        r_out_valid;
    t_out_item   r_out;
    logic        r_idx;
    logic [15:0] r_count;

    logic        load;
    logic        is_last;
    logic [7:0]  sel_byte;
    logic [15:0] cnt_new;

    assign load     = !i_q_empty && (!r_out_valid || o_out.ready);
    assign is_last  = r_idx || (i_head.num_res == 2'd1);
    assign sel_byte = r_idx ? i_head.byte1 : i_head.byte0;
    assign cnt_new  = (i_head.byte_valid && r_count != 16'hFFFF) ? r_count + 16'd1 : r_count;
    assign o_pop    = load && is_last;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 1'b0;
            r_count     <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= !is_last;
                // The count starts over after the last result of a string.
                r_count     <= (is_last && i_head.string_end) ? '0 : cnt_new;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte   <= i_head.byte_valid ? sel_byte : 8'd0;
            r_out.byte_valid <= i_head.byte_valid;
            r_out.run_last   <= is_last;
            r_out.string_end <= i_head.string_end;
            r_out.byte_count <= cnt_new;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/control_code_escape_decoder.sv
// Path: an accepted request enters the request queue, then the output register.
// Throughput: one input request per cycle while the queue has room; the output
// register moves one result per cycle while the receiver is ready, so a request
// with two bytes waits at the head of the request queue, which absorbs it.
// Reset: synchronous, active low; clears parser state, the queue, the byte count and
// the output valid. No clearing pass is needed.
`default_nettype none
`include "control_code_escape_decoder_assert.svh"
module control_code_escape_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ccd_stream_if.sink   i_in,
    ccd_stream_if.source o_out
);
    import ccd_pkg::*;

    // The front end parses one character per cycle while the queue has room and turns
    // it into a request holding zero, one or two result bytes. Requests with no result
    // (a caret, a backslash, a digit being collected) never enter the queue.
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd q_in;
    t_cmd q_head;

    ccd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    // The queue decouples the parser from output backpressure.
    ccd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end walks the bytes of each request into the output register
    // and keeps the saturating byte count for the current string.
    ccd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

    // A result without a byte only reports the end of a string.
    `CCD_ASSERT_IMPLIES(a_empty_result_ends_string, i_clk, i_rst_n,
        o_out.valid && !o_out.data.byte_valid,
        o_out.data.run_last && o_out.data.string_end && o_out.data.out_byte == 8'd0)
    // A byte that was decoded is always counted.
    `CCD_ASSERT_IMPLIES(a_count_nonzero, i_clk, i_rst_n,
        o_out.valid && o_out.data.byte_valid, o_out.data.byte_count != 16'd0)
    // A new result appears only when the queue held a request.
    `CCD_ASSERT_IMPLIES(a_result_from_queue, i_clk, i_rst_n,
        $rose(o_out.valid), $past(!q_empty))
endmodule
`default_nettype wire

// File: verif/ccd_result_checker.sv
module ccd_result_checker
    import ccd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire logic i_req_ready,
    input  t_in_item  i_req_data,
    input  wire logic i_res_valid,
    input  wire logic i_res_ready,
    input  t_out_item i_res_data,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Decoder state as the block should hold it.
    t_mode       scan_mode;
    logic [9:0]  num_acc;
    logic [2:0]  held_cnt;
    logic [7:0]  name_chars [4];
    logic [15:0] decoded_total;

    t_out_item   expected_bytes [$];
    t_out_item   step_res [2];
    int          step_n;
    int          fail_count = 0;

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - CASE_GAP : c;
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + CASE_GAP : c;
    endfunction

    function automatic bit is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_name_char(logic [7:0] c);
        return is_dec(c) || (c >= "a" && c <= "z");
    endfunction

    function automatic void clear_held();
        num_acc  = '0;
        held_cnt = '0;
        foreach (name_chars[k]) name_chars[k] = 8'h00;
    endfunction

    function automatic void reset_decoder();
        scan_mode     = MODE_NORMAL;
        decoded_total = '0;
        clear_held();
    endfunction

    // The block shows at most two results per request; anything beyond is dropped.
    function automatic void push_byte(logic [7:0] b, bit valid);
        t_out_item r;
        if (step_n >= 2) return;
        if (valid && decoded_total != 16'hFFFF) decoded_total++;
        r.out_byte   = valid ? b : 8'h00;
        r.byte_valid = valid;
        r.run_last   = 1'b0;
        r.string_end = 1'b0;
        r.byte_count = decoded_total;
        step_res[step_n] = r;
        step_n++;
    endfunction

    function automatic void plain_in(logic [7:0] c);
        scan_mode = MODE_NORMAL;
        if (c == CH_BSLASH) begin
            scan_mode = MODE_BSLASH;
        end else if (c == CH_CARET) begin
            scan_mode = MODE_CARET;
        end else begin
            push_byte(c, 1'b1);
        end
    endfunction

    // Symbolic control names; any length other than two or three never matches.
    function automatic logic [7:0] name_code();
        logic [7:0] code;
        code = 8'h00;
        if (held_cnt == 3'd2) begin
            case ({name_chars[0], name_chars[1]})
                "bs": code = 8'd8;
                "ht": code = 8'd9;
                "lf": code = 8'd10;
                "vt": code = 8'd11;
                "ff": code = 8'd12;
                "cr": code = 8'd13;
                "so": code = 8'd14;
                "si": code = 8'd15;
                "em": code = 8'd25;
                "fs": code = 8'd28;
                "gs": code = 8'd29;
                "rs": code = 8'd30;
                "us": code = 8'd31;
                "sp": code = 8'd32;
                "st": code = 8'd156;
                "pm": code = 8'd158;
                default: code = 8'h00;
            endcase
        end else if (held_cnt == 3'd3) begin
            case ({name_chars[0], name_chars[1], name_chars[2]})
                "nul": code = 8'd0;
                "soh": code = 8'd1;
                "stx": code = 8'd2;
                "etx": code = 8'd3;
                "eot": code = 8'd4;
                "enq": code = 8'd5;
                "ack": code = 8'd6;
                "bel": code = 8'd7;
                "dle": code = 8'd16;
                "dc1": code = 8'd17;
                "dc2": code = 8'd18;
                "dc3": code = 8'd19;
                "dc4": code = 8'd20;
                "nak": code = 8'd21;
                "syn": code = 8'd22;
                "etb": code = 8'd23;
                "can": code = 8'd24;
                "sub": code = 8'd26;
                "esc": code = 8'd27;
                "del": code = 8'd127;
                "ss2": code = 8'd142;
                "ss3": code = 8'd143;
                "dcs": code = 8'd144;
                "csi": code = 8'd155;
                "osc": code = 8'd157;
                "apc": code = 8'd159;
                "nbs": code = 8'd160;
                "shy": code = 8'd173;
                default: code = 8'h00;
            endcase
        end
        return code;
    endfunction

    function automatic void decode_char(t_in_item it);
        logic [7:0] c;
        logic [7:0] u;
        logic [7:0] lc;
        c      = it.in_char;
        step_n = 0;
        case (scan_mode)
            MODE_CARET: begin
                u = to_upper(c);
                push_byte((u > CH_AT && u <= CH_USCORE) ? u - CH_AT : c, 1'b1);
                scan_mode = MODE_NORMAL;
            end
            MODE_BSLASH: begin
                scan_mode = MODE_NORMAL;
                u = to_upper(c);
                if (!(u >= "0" && u <= "6")) begin
                    case (u)
                        "A", "C", "D", "G", "H", "I", "P", "U", "X": begin
                            push_byte(CH_BSLASH, 1'b1);
                            push_byte(c, 1'b1);
                        end
                        "B": push_byte(8'd8, 1'b1);
                        "F": push_byte(8'd12, 1'b1);
                        "N": push_byte(8'd10, 1'b1);
                        "R": push_byte(8'd13, 1'b1);
                        "T": push_byte(8'd9, 1'b1);
                        "E": push_byte(8'd27, 1'b1);
                        CH_STAR: begin
                            clear_held();
                            scan_mode = MODE_STAR;
                        end
                        default: push_byte(c, 1'b1);
                    endcase
                end
            end
            MODE_STAR: begin
                if (c != CH_SPACE) begin
                    lc = to_lower(c);
                    if (is_dec(c)) begin
                        num_acc   = 10'(c - "0");
                        held_cnt  = 3'd1;
                        scan_mode = MODE_DIGITS;
                    end else if (is_name_char(lc)) begin
                        name_chars[0] = lc;
                        held_cnt      = 3'd1;
                        scan_mode     = MODE_NAME;
                    end else begin
                        // Empty name: a zero byte, then the character is handled as in normal mode.
                        push_byte(8'h00, 1'b1);
                        clear_held();
                        plain_in(c);
                    end
                end
            end
            MODE_DIGITS: begin
                if (is_dec(c)) begin
                    num_acc  = 10'(num_acc * 10 + (c - "0"));
                    held_cnt = held_cnt + 3'd1;
                    if (held_cnt >= 3'd3) begin
                        push_byte(num_acc[7:0], 1'b1);
                        clear_held();
                        scan_mode = MODE_NORMAL;
                    end
                end else begin
                    push_byte(num_acc[7:0], 1'b1);
                    clear_held();
                    plain_in(c);
                end
            end
            MODE_NAME: begin
                lc = to_lower(c);
                if (is_name_char(lc)) begin
                    name_chars[held_cnt[1:0]] = lc;
                    held_cnt = held_cnt + 3'd1;
                    if (held_cnt >= 3'd4) begin
                        push_byte(name_code(), 1'b1);
                        clear_held();
                        scan_mode = MODE_NORMAL;
                    end
                end else begin
                    push_byte(name_code(), 1'b1);
                    clear_held();
                    plain_in(c);
                end
            end
            default: plain_in(c);
        endcase

        if (it.in_last) begin
            if (scan_mode == MODE_DIGITS) begin
                push_byte(num_acc[7:0], 1'b1);
            end else if (scan_mode == MODE_NAME) begin
                push_byte(name_code(), 1'b1);
            end
            if (step_n == 0) push_byte(8'h00, 1'b0);
        end

        for (int k = 0; k < step_n; k++) begin
            step_res[k].run_last   = (k == step_n - 1);
            step_res[k].string_end = it.in_last;
            expected_bytes.push_back(step_res[k]);
        end

        if (it.in_last) reset_decoder();
    endfunction

    function automatic string show_res(t_out_item r);
        return $sformatf("byte %h valid %b run_last %b end %b count %0d",
                         r.out_byte, r.byte_valid, r.run_last, r.string_end, r.byte_count);
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (expected_bytes.size() == 0) begin
            fail_count++;
            $display("%0t: result with nothing expected: %s", $time, show_res(got));
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.run_last !== want.run_last || got.string_end !== want.string_end ||
            got.byte_count !== want.byte_count) begin
            fail_count++;
            $display("%0t: mismatch, expected %s, actual %s", $time, show_res(want),
                     show_res(got));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_decoder();
            expected_bytes.delete();
        end else begin
            if (i_req_valid && i_req_ready) decode_char(i_req_data);
            if (i_res_valid && i_res_ready) check_result(i_res_data);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_bytes.size();
    end

endmodule

// File: verif/tb_control_code_escape_decoder.sv
module tb_control_code_escape_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import ccd_pkg::*;

    // Random strings until this many requests follow the directed part.
    localparam int RANDOM_ITEMS    = 1925;
    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_CYCLES    = 20;

    // Characters tried after a backslash: every code letter in both cases, the
    // star, the silent digits and a few that pass through raw.
    localparam string BS_SET = "BFNRTEACDGHIPUXbfnrteacdghipux*0123456789qZ";
    // Characters that end a star code with an empty name.
    localparam string PUNCT_SET = "!,.;-~^\\";

    // Ways the receiver paces its ready.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } t_rx_style;

    logic i_clk;
    logic i_rst_n;

    ccd_stream_if #(.T(t_in_item))  req_ch ();
    ccd_stream_if #(.T(t_out_item)) res_ch ();

    int fail_count;
    int pending_count;
    int sent_count = 0;
    int cycle_count;

    // The whole request stream is built before reset is released.
    t_in_item   stim_q [$];
    logic [7:0] text_q [$];

    // The table names plus a few that never match.
    string sym_pool [50] = '{
        "nul", "soh", "stx", "etx", "eot", "enq", "ack", "bel", "bs", "ht",
        "lf", "vt", "ff", "cr", "so", "si", "dle", "dc1", "dc2", "dc3",
        "dc4", "nak", "syn", "etb", "can", "em", "sub", "esc", "fs", "gs",
        "rs", "us", "sp", "del", "ss2", "ss3", "dcs", "csi", "st", "osc",
        "pm", "apc", "nbs", "shy", "abcd", "zz", "q", "x9", "d5", "dc9"
    };

    control_code_escape_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    ccd_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_data   (req_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // Turns the characters gathered so far into one string of requests, with
    // the last flag on its final character.
    function automatic void close_text();
        t_in_item it;
        for (int i = 0; i < text_q.size(); i++) begin
            it.in_char = text_q[i];
            it.in_last = (i == text_q.size() - 1);
            stim_q.push_back(it);
        end
        text_q.delete();
    endfunction

    // One escape construct, mostly well formed, sometimes plain noise.
    function automatic void add_token();
        int         kind;
        string      nm;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            // Any byte at all, which now and then is a bare caret or backslash.
            text_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 38) begin
            text_q.push_back(CH_CARET);
            if ($urandom_range(0, 3) == 0) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                c = 8'($urandom_range(8'h40, 8'h7F));
            end
            text_q.push_back(c);
        end else if (kind < 58) begin
            text_q.push_back(CH_BSLASH);
            if ($urandom_range(0, 4) == 0) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                c = BS_SET[$urandom_range(0, BS_SET.len() - 1)];
            end
            text_q.push_back(c);
        end else begin
            // Star codes, with any leading spaces skipped by the block.
            put_str("\\*");
            repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
            if (kind < 72) begin
                repeat ($urandom_range(1, 3)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
            end else if (kind < 92) begin
                nm = sym_pool[$urandom_range(0, 49)];
                for (int i = 0; i < nm.len(); i++) begin
                    c = nm[i];
                    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - CASE_GAP;
                    text_q.push_back(c);
                end
            end else begin
                text_q.push_back(PUNCT_SET[$urandom_range(0, PUNCT_SET.len() - 1)]);
            end
        end
    endfunction

    function automatic void add_string();
        repeat ($urandom_range(1, 8)) add_token();
        // Sometimes the string stops on an unfinished prefix, which must give
        // only the empty count report.
        if ($urandom_range(0, 6) == 0) begin
            case ($urandom_range(0, 2))
                0: text_q.push_back(CH_CARET);
                1: text_q.push_back(CH_BSLASH);
                default: put_str("\\*");
            endcase
        end
        close_text();
    endfunction

    function automatic void build_stimulus();
        int directed;
        // Extremes of the character, a control caret, a silent digit, a macro
        // letter that gives two bytes.
        text_q.push_back(8'h00);
        put_str("^a\\3\\x");
        text_q.push_back(8'hFF);
        close_text();
        // A spaced number that wraps modulo 256, a name ended by a character
        // that is reprocessed, an empty name, and a number pending at the end.
        put_str("\\* 999\\*Csi!\\*!\\*7");
        close_text();
        directed = stim_q.size();

        while (stim_q.size() < directed + RANDOM_ITEMS) add_string();
    endfunction

    // Sender: reset, then bursts of requests with random gaps. A gap of zero
    // keeps valid high across the burst boundary, so there are long stretches
    // with no idling at all.
    initial begin : stimulus
        int idx;
        int burst;
        int gap;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        build_stimulus();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx = 0;
        while (idx < stim_q.size()) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            for (int b = 0; b < burst && idx < stim_q.size(); b++) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= stim_q[idx];
                @(posedge i_clk);
                while (!req_ch.ready) @(posedge i_clk);
                idx++;
                sent_count++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_ch.valid <= 1'b0;

        // The checker's count of outstanding bytes is registered, so step past its update
        // before trusting it, then let the pipeline settle.
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver: stretches of different ready patterns. Once, early in the
    // random part, it holds ready low long enough for the request queue to
    // fill while the sender keeps offering, so the input stalls.
    initial begin : receiver
        int        stretch;
        t_rx_style style;
        bit        held_off;
        res_ch.ready <= 1'b0;
        held_off = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held_off && sent_count >= 120) begin
                held_off = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            stretch = $urandom_range(5, 60);
            style   = t_rx_style'($urandom_range(0, 3));
            for (int k = 0; k < stretch; k++) begin
                case (style)
                    RX_OPEN:   res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   res_ch.ready <= (k % 3 != 2);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on total run length.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ccd_pkg.sv
hw/rtl/ccd_stream_if.sv
hw/rtl/ccd_fifo.sv
hw/rtl/ccd_front.sv
hw/rtl/ccd_back.sv
hw/rtl/control_code_escape_decoder.sv
verif/ccd_result_checker.sv
verif/tb_control_code_escape_decoder.sv
